/* hw/rtl/mbps_pkg.sv */
// Shared types and constants of the masked byte pattern scanner.
package mbps_pkg;

    // Index arithmetic width: covers cell positions up to 511.
    localparam int IDX_W  = 9;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam int LEN_W  = 7;
    localparam int ADR_W  = 32;

    // Register index (paddr bit 2).
    localparam logic REG_LEN  = 1'b0;
    localparam logic REG_BASE = 1'b1;

    // Item kinds.
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    // Broadcast from the control to every cell of the window chain.
    typedef struct packed {
        logic       shift;
        logic [7:0] pat_byte;
        logic       pat_care;
    } t_cell_bus;

endpackage

/* hw/rtl/mbps_ram.sv */
// Generic single-port-write, registered-read RAM.
module mbps_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/mbps_cell.sv */
// One window cell: a byte of the shift line plus its aligned pattern byte and care bit.
module mbps_cell (
    input  logic                 i_clk,
    input  mbps_pkg::t_cell_bus  i_bus,
    input  logic [7:0]           i_byte,
    input  logic                 i_pat_we,
    input  logic                 i_active,
    output logic [7:0]           o_byte,
    output logic                 o_hit
);

    logic [7:0] r_win;
    logic [7:0] r_pat;
    logic       r_care;

    always_ff @(posedge i_clk) begin
        if (i_bus.shift) begin
            r_win <= i_byte;
        end
        if (i_pat_we) begin
            r_pat  <= i_bus.pat_byte;
            r_care <= i_bus.pat_care;
        end
    end

    assign o_byte = r_win;
    // Cells past the pattern length and wildcard positions always pass.
    assign o_hit  = !i_active || !r_care || (r_win == r_pat);

endmodule

/* hw/rtl/masked_byte_pattern_scanner_top.sv */
// Top level of the masked byte pattern scanner: control, window chain and result register.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_kind, i_pattern_index, i_pattern_byte,
//          |           |                            | i_pattern_care, i_data_byte, i_last_byte
//  out     | output    | o_out_valid / i_out_stall  | o_found, o_match_address
//  cfg     | input     | APB psel/penable/pready    | paddr, pwdata, prdata
//
// One item per cycle while o_in_stall is low. A data item shifts the cell chain on acceptance; the
// scan stage registers its window offset, then the masked compare of all cells and the address add
// land in the result register. A write of pattern_length realigns the pattern into the cells from
// the pattern RAM; no item is accepted during the sweep. A result that meets a stalled output goes
// to a skid register; input stalls while it is full or while a sweep runs.
// Synchronous active-low reset clears control state; the pattern is undefined until loaded.
module masked_byte_pattern_scanner_top #(
    parameter int PATTERN_MAX = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // item input
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_kind,
    input  logic [5:0]                    i_pattern_index,
    input  logic [7:0]                    i_pattern_byte,
    input  logic                          i_pattern_care,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_last_byte,
    // result output
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_found,
    output logic [mbps_pkg::ADR_W-1:0]    o_match_address,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mbps_pkg::APB_AW-1:0]   paddr,
    input  logic [mbps_pkg::APB_DW-1:0]   pwdata,
    output logic [mbps_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    import mbps_pkg::*;

    localparam int AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    // configuration registers
    logic [LEN_W-1:0] r_len;
    logic [ADR_W-1:0] r_base;
    logic             cfg_wr;

    // realignment sweep
    logic             r_sweep;
    logic [IDX_W-1:0] r_k;
    logic             r_rd_v;
    logic [IDX_W-1:0] r_rd_idx;
    logic [8:0]       ram_rdata;

    // scan stage
    logic [ADR_W-1:0] r_seen;
    logic [ADR_W-1:0] n_seen;
    logic             r_v1;
    logic             r_last1;
    logic             r_ge1;
    logic [ADR_W-1:0] r_ofs1;
    logic             r_reported;

    // result register and skid register
    logic             r_out_valid;
    logic             r_found;
    logic [ADR_W-1:0] r_addr;
    logic             r_skid_v;
    logic             r_skid_found;
    logic [ADR_W-1:0] r_skid_addr;

    logic             adv;
    logic             out_acc;
    logic             in_acc;
    logic             data_acc;
    logic             load_acc;
    logic [IDX_W-1:0] len_eff;
    logic [IDX_W-1:0] len_ext;
    logic             sat;
    logic [IDX_W-1:0] sub_op;
    logic [ADR_W:0]   diff;
    logic [IDX_W-1:0] src_idx;
    logic             src_valid;
    logic             pat_wr;
    logic [IDX_W-1:0] tgt;
    logic             hit;
    logic             res_v;
    logic [ADR_W-1:0] res_addr;
    logic             all_match;

    t_cell_bus        bus;
    logic [7:0]       chain [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] cell_hit;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[2])
            REG_LEN:  prdata = APB_DW'(r_len);
            REG_BASE: prdata = r_base;
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= LEN_W'(1);
            r_base <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_LEN:  r_len  <= pwdata[LEN_W-1:0];
                REG_BASE: r_base <= pwdata;
                default:  ;
            endcase
        end
    end

    // clamp: 0 acts as 1, above PATTERN_MAX acts as PATTERN_MAX
    assign len_ext = IDX_W'(r_len);
    always_comb begin
        if (r_len == '0) begin
            len_eff = IDX_W'(1);
        end else if (len_ext > IDX_W'(PATTERN_MAX)) begin
            len_eff = IDX_W'(PATTERN_MAX);
        end else begin
            len_eff = len_ext;
        end
    end

    // ---------------- handshake ----------------
    assign adv        = !r_skid_v;
    assign out_acc    = r_out_valid && !i_out_stall;
    assign o_in_stall = r_skid_v || r_sweep || r_rd_v;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign data_acc   = in_acc && (i_kind == KIND_DATA);
    assign load_acc   = in_acc && (i_kind == KIND_LOAD);

    // ---------------- pattern RAM and realignment sweep ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep  <= 1'b0;
            r_k      <= '0;
            r_rd_v   <= 1'b0;
            r_rd_idx <= '0;
        end else begin
            r_rd_v <= 1'b0;
            if (cfg_wr && paddr[2] == REG_LEN) begin
                r_sweep <= 1'b1;
                r_k     <= '0;
            end else if (r_sweep) begin
                if (r_k == IDX_W'(PATTERN_MAX)) begin
                    r_sweep <= 1'b0;
                end else begin
                    r_rd_v   <= 1'b1;
                    r_rd_idx <= r_k;
                    r_k      <= r_k + IDX_W'(1);
                end
            end
        end
    end

    mbps_ram #(
        .WIDTH (9),
        .DEPTH (PATTERN_MAX)
    ) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (load_acc && (IDX_W'(i_pattern_index) < IDX_W'(PATTERN_MAX))),
        .i_waddr (AW'(IDX_W'(i_pattern_index))),
        .i_wdata ({i_pattern_care, i_pattern_byte}),
        .i_re    (r_sweep && (r_k != IDX_W'(PATTERN_MAX))),
        .i_raddr (AW'(r_k)),
        .o_rdata (ram_rdata)
    );

    // Pattern position p sits in the cell of age len-1-p.
    always_comb begin
        if (r_rd_v) begin
            src_valid    = 1'b1;
            src_idx      = r_rd_idx;
            bus.pat_byte = ram_rdata[7:0];
            bus.pat_care = ram_rdata[8];
        end else begin
            src_valid    = load_acc;
            src_idx      = IDX_W'(i_pattern_index);
            bus.pat_byte = i_pattern_byte;
            bus.pat_care = i_pattern_care;
        end
        bus.shift = data_acc;
        pat_wr    = src_valid && (src_idx < len_eff);
        tgt       = len_eff - IDX_W'(1) - src_idx;
    end

    // ---------------- window chain ----------------
    for (genvar a = 0; a < PATTERN_MAX; a++) begin : g_cell
        logic [7:0] prev;
        if (a == 0) begin : g_head
            assign prev = i_data_byte;
        end else begin : g_link
            assign prev = chain[a-1];
        end
        mbps_cell u_cell (
            .i_clk    (i_clk),
            .i_bus    (bus),
            .i_byte   (prev),
            .i_pat_we (pat_wr && (tgt == IDX_W'(a))),
            .i_active (IDX_W'(a) < len_eff),
            .o_byte   (chain[a]),
            .o_hit    (cell_hit[a])
        );
    end

    assign all_match = &cell_hit;

    // ---------------- scan stage ----------------
    assign sat    = (r_seen == '1);
    // offset of the window ending at the new byte: seen+1-len, or seen-len once saturated
    assign sub_op = sat ? len_eff : (len_eff - IDX_W'(1));
    assign diff   = {1'b0, r_seen} - (ADR_W + 1)'(sub_op);

    always_comb begin
        if (i_last_byte) begin
            n_seen = '0;
        end else if (sat) begin
            n_seen = r_seen;
        end else begin
            n_seen = r_seen + ADR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_v1   <= 1'b0;
        end else if (adv) begin
            r_v1 <= data_acc;
            if (data_acc) begin
                r_seen <= n_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && data_acc) begin
            r_last1 <= i_last_byte;
            r_ge1   <= !diff[ADR_W];
            r_ofs1  <= diff[ADR_W-1:0];
        end
    end

    // ---------------- compare and result ----------------
    assign hit      = r_v1 && r_ge1 && all_match && !r_reported;
    assign res_v    = adv && (hit || (r_v1 && r_last1 && !r_reported));
    assign res_addr = hit ? (r_base + r_ofs1) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reported  <= 1'b0;
            r_out_valid <= 1'b0;
            r_skid_v    <= 1'b0;
        end else begin
            if (adv && r_v1) begin
                r_reported <= r_last1 ? 1'b0 : (r_reported || hit);
            end
            if (r_skid_v) begin
                if (out_acc) begin
                    r_skid_v <= 1'b0;
                end
            end else if (res_v) begin
                if (r_out_valid && !out_acc) begin
                    r_skid_v <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // skid entry moves up when the waiting item leaves
    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (out_acc) begin
                r_found <= r_skid_found;
                r_addr  <= r_skid_addr;
            end
        end else if (res_v) begin
            if (r_out_valid && !out_acc) begin
                r_skid_found <= hit;
                r_skid_addr  <= res_addr;
            end else begin
                r_found <= hit;
                r_addr  <= res_addr;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_found         = r_found;
    assign o_match_address = r_addr;

endmodule
